@@ rtl/ntrq_pkg.sv @@
`default_nettype none
package ntrq_pkg;

  localparam int TAG_BYTES   = 540;
  localparam int QUEUE_SLOTS = 4;
  localparam int CRC_POS     = 312;
  localparam int CNT_W       = 10;

  localparam logic [7:0] CMD_HEAD_BYTE = 8'h11;
  localparam logic [7:0] CMD_ID_STATUS = 8'h01;
  localparam logic [7:0] CMD_ID_NFC    = 8'h02;
  localparam logic [7:0] SUB_START     = 8'h01;
  localparam logic [7:0] SUB_STOP      = 8'h02;
  localparam logic [7:0] SUB_POLL      = 8'h04;
  localparam logic [7:0] SUB_READ      = 8'h06;
  localparam logic [7:0] IDLE_BYTE     = 8'hff;
  localparam logic [7:0] CRC_POLY      = 8'h07;
  localparam logic [3:0] POLL_FIRST    = 4'd1;
  localparam logic [3:0] POLL_AGAIN    = 4'd9;
  localparam logic [2:0] POWER_NFC     = 3'd4;

  typedef enum logic [3:0] {
    ACT_RESET   = 4'd0,
    ACT_POWER   = 4'd1,
    ACT_MODE    = 4'd2,
    ACT_TAG     = 4'd3,
    ACT_LOAD    = 4'd4,
    ACT_UNLOAD  = 4'd5,
    ACT_COMMAND = 4'd6,
    ACT_READ    = 4'd7,
    ACT_ADVANCE = 4'd8
  } ntrq_action_e;

  typedef enum logic [2:0] {
    K_STAT_OFF = 3'd0,
    K_STAT_ON  = 3'd1,
    K_POLL     = 3'd2,
    K_READ1    = 3'd3,
    K_READ2    = 3'd4,
    K_READ3    = 3'd5
  } ntrq_kind_e;

  typedef struct packed {
    logic [3:0] action;
    logic [7:0] value;
    logic [9:0] index;
    logic [9:0] length;
    logic [7:0] cmd_head;
    logic [7:0] cmd_id;
    logic [7:0] sub_id;
    logic       args_clear;
  } ntrq_in_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] read_byte;
  } ntrq_out_t;

  // controller to datapath
  typedef struct packed {
    logic             restart;
    logic             tag_wr;
    logic [9:0]       tag_addr;
    logic [7:0]       tag_data;
    logic             clr_step;
    logic             gen_addr;
    logic             gen_write;
    ntrq_kind_e       kind;
    logic [1:0]       slot;
    logic             found;
    logic [2:0]       power;
    logic [3:0]       poll;
    logic             rd;
    logic [1:0]       rd_slot;
    logic [9:0]       rd_index;
  } ntrq_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       gen_last;
    logic [7:0] rd_byte;
  } ntrq_sts_t;

  typedef struct packed {
    logic       from_tag;
    logic [9:0] tag_addr;
    logic       sel_power;
    logic       sel_poll;
    logic [7:0] byte_val;
  } ntrq_src_t;

  localparam logic [7:0] READ_WIRE [15] = '{8'h3a,8'h00,8'h07,8'h01,8'h00,8'h01,8'h31,8'h02,
                                            8'h00,8'h00,8'h00,8'h01,8'h02,8'h00,8'h07};
  localparam logic [7:0] READ_META [45] = '{
    8'h00,8'h00,8'h00,8'h00,8'h7d,8'hfd,8'hf0,8'h79,8'h36,8'h51,8'hab,8'hd7,8'h46,8'h6e,
    8'h39,8'hc1,8'h91,8'hba,8'hbe,8'hb8,8'h56,8'hce,8'hed,8'hf1,8'hce,8'h44,
    8'hcc,8'h75,8'hea,8'hfb,8'h27,8'h09,8'h4d,8'h08,8'h7a,8'he8,8'h03,8'h00,8'h3b,8'h3c,
    8'h77,8'h78,8'h86,8'h00,8'h00};
  localparam logic [7:0] READ_SECOND [7] = '{8'h3a,8'h00,8'h07,8'h02,8'h00,8'h09,8'h27};
  localparam logic [7:0] READ_TAIL [16] = '{8'h2a,8'h00,8'h05,8'h00,8'h00,8'h09,8'h31,8'h04,
                                            8'h00,8'h00,8'h00,8'h01,8'h01,8'h02,8'h00,8'h07};
  localparam logic [7:0] POLL_HDR [7] = '{8'h2a,8'h00,8'h05,8'h00,8'h00,8'h09,8'h31};
  localparam logic [7:0] POLL_FOUND [8] = '{8'h00,8'h00,8'h00,8'h01,8'h01,8'h02,8'h00,8'h07};
  localparam logic [7:0] STATUS_HDR [7] = '{8'h01,8'h00,8'h00,8'h00,8'h08,8'h00,8'h1b};

  function automatic logic [7:0] crc8_step(logic [7:0] c, logic [7:0] d);
    logic [7:0] r;
    r = c ^ d;
    for (int b = 0; b < 8; b++) begin
      r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  function automatic logic [7:0] crc_idle();
    logic [7:0] c;
    c = crc8_step(8'h00, IDLE_BYTE);
    for (int i = 1; i < CRC_POS; i++) begin
      c = crc8_step(c, 8'h00);
    end
    return c;
  endfunction

  localparam logic [7:0] CRC_IDLE = crc_idle();

  // UID byte j of a response: tag bytes 0..2, then 4..7
  function automatic logic [9:0] uid_addr(logic [9:0] j);
    return (j < 10'd3) ? j : j + 10'd1;
  endfunction

  function automatic ntrq_src_t gen_src(ntrq_kind_e kind, logic [9:0] k, logic found);
    ntrq_src_t  s;
    logic [9:0] off;
    s   = '0;
    off = '0;
    case (kind)
      K_STAT_OFF: begin
        if (k == 10'd0) s.byte_val = IDLE_BYTE;
      end
      K_STAT_ON: begin
        if (k < 10'd7) s.byte_val = STATUS_HDR[k[2:0]];
        else if (k == 10'd7) s.sel_power = 1'b1;
      end
      K_POLL: begin
        if (k < 10'd7) s.byte_val = POLL_HDR[k[2:0]];
        else if (k == 10'd7) s.sel_poll = 1'b1;
        else if (found && k < 10'd16) begin
          off = k - 10'd8;
          s.byte_val = POLL_FOUND[off[2:0]];
        end else if (found && k < 10'd23) begin
          s.from_tag = 1'b1;
          s.tag_addr = uid_addr(k - 10'd16);
        end
      end
      K_READ1: begin
        if (k < 10'd15) s.byte_val = READ_WIRE[k[3:0]];
        else if (k < 10'd22) begin
          s.from_tag = 1'b1;
          s.tag_addr = uid_addr(k - 10'd15);
        end else if (k < 10'd67) begin
          off = k - 10'd22;
          s.byte_val = READ_META[off[5:0]];
        end else if (k < 10'd312) begin
          s.from_tag = 1'b1;
          s.tag_addr = k - 10'd67;
        end
      end
      K_READ2: begin
        if (k < 10'd7) s.byte_val = READ_SECOND[k[2:0]];
        else if (k < 10'd302) begin
          s.from_tag = 1'b1;
          s.tag_addr = k + 10'd238;
        end
      end
      K_READ3: begin
        if (k < 10'd16) s.byte_val = READ_TAIL[k[3:0]];
        else if (k < 10'd23) begin
          s.from_tag = 1'b1;
          s.tag_addr = uid_addr(k - 10'd16);
        end
      end
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

@@ rtl/nfc_tag_response_queue_unit.sv @@
`default_nettype none
// Channel  Dir  Handshake              Beat
// in       in   in_valid_i/in_stall_o  ntrq_in_t  (action, value, index, length, ...)
// out      out  out_valid_o/out_stall_i ntrq_out_t (ok, read_byte)
//
// One item at a time; every item yields exactly one result beat.
// A queue read adds a response RAM read before the result; each built response
// is written byte by byte (tag RAM read, then response RAM write), one packet of
// PACKET_BYTES for a status or poll and three for a tag read.
// Unload adds a sweep zeroing all 540 tag RAM bytes.
// Reset clears flags, modes and queue pointers; RAM contents are left as is.
// A stalled result holds in the output register; the next item is still accepted and waits in its done state.
module nfc_tag_response_queue_unit
  import ntrq_pkg::*;
#(
  parameter int PACKET_BYTES = 313
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire ntrq_in_t in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output ntrq_out_t     out_item_o
);

  ntrq_cmd_t cmd;
  ntrq_sts_t sts;

  // decode actions, own the tag/poll/queue state, sequence response builds
  ntrq_ctrl #(.PACKET_BYTES(PACKET_BYTES)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // tag and response RAMs, byte counter, byte mux and running CRC
  ntrq_dp #(.PACKET_BYTES(PACKET_BYTES)) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule
`default_nettype wire

@@ rtl/ntrq_ram.sv @@
`default_nettype none
module ntrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 540,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ rtl/ntrq_dp.sv @@
`default_nettype none
module ntrq_dp
  import ntrq_pkg::*;
#(
  parameter int PACKET_BYTES = 313
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ntrq_cmd_t cmd_i,
  output ntrq_sts_t      sts_o
);

  localparam int RAW = $clog2(QUEUE_SLOTS * PACKET_BYTES);
  localparam int TAW = $clog2(TAG_BYTES);

  logic [CNT_W-1:0] k_q, k_d;
  logic [7:0]       crc_q, crc_d;
  logic [7:0]       tag_rdata, resp_rdata, wbyte, src_byte;
  ntrq_src_t        src;

  logic             tag_we;
  logic [TAW-1:0]   tag_waddr;
  logic [7:0]       tag_wdata;
  logic [RAW-1:0]   resp_waddr, resp_raddr;

  assign src = gen_src(cmd_i.kind, k_q, cmd_i.found);

  always_comb begin
    if (src.from_tag) src_byte = tag_rdata;
    else if (src.sel_power) src_byte = {5'b0, cmd_i.power};
    else if (src.sel_poll) src_byte = {4'b0, cmd_i.poll};
    else src_byte = src.byte_val;
    if (k_q < CNT_W'(CRC_POS)) wbyte = src_byte;
    else if (k_q == CNT_W'(CRC_POS)) wbyte = crc_q;
    else wbyte = 8'h00;
  end

  // sweep writes zero, otherwise a staged tag byte
  assign tag_we    = cmd_i.tag_wr | cmd_i.clr_step;
  assign tag_waddr = cmd_i.clr_step ? k_q[TAW-1:0] : cmd_i.tag_addr[TAW-1:0];
  assign tag_wdata = cmd_i.clr_step ? 8'h00 : cmd_i.tag_data;

  ntrq_ram #(.WIDTH(8), .DEPTH(TAG_BYTES)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_wdata),
    .re_i    (cmd_i.gen_addr),
    .raddr_i (src.tag_addr[TAW-1:0]),
    .rdata_o (tag_rdata)
  );

  assign resp_waddr = RAW'(cmd_i.slot) * RAW'(PACKET_BYTES) + RAW'(k_q);
  assign resp_raddr = RAW'(cmd_i.rd_slot) * RAW'(PACKET_BYTES) + RAW'(cmd_i.rd_index);

  ntrq_ram #(.WIDTH(8), .DEPTH(QUEUE_SLOTS * PACKET_BYTES)) u_resp_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.gen_write),
    .waddr_i (resp_waddr),
    .wdata_i (wbyte),
    .re_i    (cmd_i.rd),
    .raddr_i (resp_raddr),
    .rdata_o (resp_rdata)
  );

  always_comb begin
    k_d   = k_q;
    crc_d = crc_q;
    if (cmd_i.restart) begin
      k_d   = '0;
      crc_d = 8'h00;
    end else if (cmd_i.clr_step || cmd_i.gen_write) begin
      k_d = k_q + CNT_W'(1);
      if (cmd_i.gen_write && k_q < CNT_W'(CRC_POS)) crc_d = crc8_step(crc_q, wbyte);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= '0;
      crc_q <= 8'h00;
    end else begin
      k_q   <= k_d;
      crc_q <= crc_d;
    end
  end

  assign sts_o.clr_last = (k_q == CNT_W'(TAG_BYTES - 1));
  assign sts_o.gen_last = (k_q == CNT_W'(PACKET_BYTES - 1));
  assign sts_o.rd_byte  = resp_rdata;

endmodule
`default_nettype wire

@@ rtl/ntrq_ctrl.sv @@
`default_nettype none
module ntrq_ctrl
  import ntrq_pkg::*;
#(
  parameter int PACKET_BYTES = 313
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire ntrq_in_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output ntrq_out_t      out_item_o,
  output ntrq_cmd_t      cmd_o,
  input  wire ntrq_sts_t sts_i
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CLR  = 6'b000010,
    S_GA   = 6'b000100,
    S_GW   = 6'b001000,
    S_RD   = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e     state_q, state_d;
  logic       present_q, present_d, reported_q, reported_d;
  logic [2:0] power_q, power_d;
  logic [3:0] poll_q, poll_d;
  logic [1:0] head_q, head_d;
  logic [2:0] count_q, count_d;
  ntrq_kind_e kind_q, kind_d;
  logic [1:0] slot_q, slot_d, pkts_q, pkts_d;
  logic       found_q, found_d, gen_pend_q, gen_pend_d;
  logic       ok_q, ok_d;
  logic [7:0] rb_q, rb_d;
  logic       out_valid_q, out_valid_d;
  ntrq_out_t  out_q, out_d;

  logic       accept, emp, push, push_rd, go_clr, go_rd, go_gen, out_free;
  ntrq_kind_e pkind;
  logic [1:0] head_n;
  logic [2:0] cnt_n;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    present_d  = present_q;
    reported_d = reported_q;
    power_d    = power_q;
    poll_d     = poll_q;
    head_d     = head_q;
    count_d    = count_q;
    kind_d     = kind_q;
    slot_d     = slot_q;
    pkts_d     = pkts_q;
    found_d    = found_q;
    gen_pend_d = gen_pend_q;
    ok_d       = ok_q;
    rb_d       = rb_q;
    state_d    = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d      = out_q;
    emp        = 1'b0;
    push       = 1'b0;
    push_rd    = 1'b0;
    pkind      = K_STAT_OFF;
    go_clr     = 1'b0;
    go_rd      = 1'b0;
    go_gen     = 1'b0;
    head_n     = head_q;
    cnt_n      = count_q;

    cmd_o          = '0;
    cmd_o.tag_addr = in_item_i.index;
    cmd_o.tag_data = in_item_i.value;
    cmd_o.kind     = kind_q;
    cmd_o.slot     = slot_q;
    cmd_o.found    = found_q;
    cmd_o.power    = power_q;
    cmd_o.poll     = poll_q;
    cmd_o.rd_slot  = head_q;
    cmd_o.rd_index = in_item_i.index;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          ok_d = 1'b1;
          rb_d = 8'h00;
          cmd_o.restart = 1'b1;
          case (in_item_i.action)
            ACT_RESET: begin
              emp = 1'b1; power_d = '0; poll_d = '0; reported_d = 1'b0;
            end
            ACT_POWER: begin
              if (in_item_i.value > 8'd1) ok_d = 1'b0;
              else begin
                emp = 1'b1; power_d = in_item_i.value[2:0]; poll_d = '0;
                reported_d = 1'b0; push = 1'b1;
              end
            end
            ACT_MODE: begin
              if (in_item_i.length < 10'd3 ||
                  (in_item_i.value != 8'd0 && in_item_i.value != 8'd1 &&
                   in_item_i.value != 8'd4)) ok_d = 1'b0;
              else if (power_q != 3'd0 && in_item_i.value != 8'd0) begin
                power_d = in_item_i.value[2:0]; poll_d = '0; reported_d = 1'b0;
                emp = 1'b1; push = 1'b1;
              end
            end
            ACT_TAG: begin
              if (in_item_i.index < 10'(TAG_BYTES)) cmd_o.tag_wr = 1'b1;
              else ok_d = 1'b0;
            end
            ACT_LOAD: begin
              if (in_item_i.length != 10'(TAG_BYTES)) ok_d = 1'b0;
              else begin
                present_d = 1'b1; reported_d = 1'b0; emp = 1'b1;
                if (power_q == POWER_NFC && poll_q != 4'd0) begin
                  poll_d = POLL_FIRST; push = 1'b1; pkind = K_POLL;
                end else if (power_q != 3'd0) push = 1'b1;
              end
            end
            ACT_UNLOAD: begin
              present_d = 1'b0; reported_d = 1'b0; emp = 1'b1; go_clr = 1'b1;
              if (poll_q != 4'd0) begin
                poll_d = POLL_FIRST;
                if (power_q == POWER_NFC) begin
                  push = 1'b1; pkind = K_POLL;
                end
              end
            end
            ACT_COMMAND: begin
              if (in_item_i.length < 10'd11 || in_item_i.cmd_head != CMD_HEAD_BYTE) ok_d = 1'b0;
              else if (in_item_i.cmd_id == CMD_ID_STATUS) push = 1'b1;
              else if (in_item_i.cmd_id != CMD_ID_NFC || in_item_i.length < 10'd12 ||
                       power_q != POWER_NFC) ok_d = 1'b0;
              else begin
                case (in_item_i.sub_id)
                  SUB_START: poll_d = POLL_FIRST;
                  SUB_STOP: begin
                    poll_d = '0; reported_d = 1'b0; emp = 1'b1;
                  end
                  SUB_POLL: begin
                    push = 1'b1; pkind = K_POLL;
                  end
                  SUB_READ: begin
                    if (in_item_i.length < 10'd25 || !present_q || !in_item_i.args_clear)
                      ok_d = 1'b0;
                    else push_rd = 1'b1;
                  end
                  default: ok_d = 1'b0;
                endcase
              end
            end
            ACT_READ: begin
              if (in_item_i.index >= 10'(PACKET_BYTES)) ok_d = 1'b0;
              else if (count_q != 3'd0) begin
                go_rd = 1'b1; cmd_o.rd = 1'b1;
              end else if (in_item_i.index == 10'd0) rb_d = IDLE_BYTE;
              else if (in_item_i.index == 10'(CRC_POS)) rb_d = CRC_IDLE;
            end
            ACT_ADVANCE: begin
              if (count_q != 3'd0) begin
                head_d  = head_q + 2'd1;
                count_d = count_q - 3'd1;
              end
            end
            default: ok_d = 1'b0;
          endcase

          // queue claim
          if (emp) begin
            head_n = '0;
            cnt_n  = '0;
            head_d = '0;
            count_d = '0;
          end
          if (push_rd) begin
            head_d = '0; count_d = 3'd3; slot_d = 2'd0; pkts_d = 2'd2;
            kind_d = K_READ1; found_d = 1'b0; go_gen = 1'b1;
          end else if (push && cnt_n < 3'(QUEUE_SLOTS)) begin
            go_gen  = 1'b1;
            slot_d  = head_n + cnt_n[1:0];
            count_d = cnt_n + 3'd1;
            pkts_d  = 2'd0;
            found_d = 1'b0;
            if (pkind == K_POLL) begin
              kind_d = K_POLL;
              if (present_d && poll_d != 4'd0) begin
                poll_d     = reported_d ? POLL_AGAIN : POLL_FIRST;
                reported_d = 1'b1;
                found_d    = 1'b1;
              end
            end else begin
              kind_d = (power_d == 3'd0) ? K_STAT_OFF : K_STAT_ON;
            end
          end
          gen_pend_d = go_gen;
          if (go_clr) state_d = S_CLR;
          else if (go_gen) state_d = S_GA;
          else if (go_rd) state_d = S_RD;
          else state_d = S_DONE;
        end
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          // rewind the byte counter for the build that may follow
          cmd_o.restart = 1'b1;
          state_d = gen_pend_q ? S_GA : S_DONE;
        end
      end
      S_GA: begin
        cmd_o.gen_addr = 1'b1;
        state_d = S_GW;
      end
      S_GW: begin
        cmd_o.gen_write = 1'b1;
        state_d = S_GA;
        if (sts_i.gen_last) begin
          if (pkts_q != 2'd0) begin
            // next read fragment goes to the following slot
            cmd_o.restart = 1'b1;
            pkts_d = pkts_q - 2'd1;
            slot_d = slot_q + 2'd1;
            kind_d = (kind_q == K_READ1) ? K_READ2 : K_READ3;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_RD: begin
        rb_d    = sts_i.rd_byte;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d.ok    = ok_q;
          out_d.read_byte = rb_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      present_q   <= 1'b0;
      reported_q  <= 1'b0;
      power_q     <= '0;
      poll_q      <= '0;
      head_q      <= '0;
      count_q     <= '0;
      gen_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      present_q   <= present_d;
      reported_q  <= reported_d;
      power_q     <= power_d;
      poll_q      <= poll_d;
      head_q      <= head_d;
      count_q     <= count_d;
      gen_pend_q  <= gen_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    slot_q  <= slot_d;
    pkts_q  <= pkts_d;
    found_q <= found_d;
    ok_q    <= ok_d;
    rb_q    <= rb_d;
    out_q   <= out_d;
  end

endmodule
`default_nettype wire
